// File: hdl/mmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmv_pkg;

    // configuration of the statistics engine
    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int PIXEL_WIDTH     = 16;

    // fixed field widths of the channels
    localparam int PIX_IN_W  = 16;
    localparam int MEAN_W    = 16;
    localparam int VAR_W     = 31;
    localparam int COUNT_W   = 21;

    // internal widths
    localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
    localparam int SUM_W  = PIXEL_WIDTH + MAX_PIXELS_LOG2;
    localparam int MAG_W  = PIXEL_WIDTH;
    localparam int SQ_W   = 2 * PIXEL_WIDTH;
    localparam int SSQ_W  = 2 * PIXEL_WIDTH + MAX_PIXELS_LOG2;
    localparam int ACC_W  = CNT_W + SSQ_W;
    localparam int QUO_W  = 2 * PIXEL_WIDTH - 1;
    localparam int NN_W   = 2 * CNT_W;

    localparam int MAX_ITER = (SUM_W > QUO_W) ? SUM_W : QUO_W;
    localparam int ITER_W   = $clog2(MAX_ITER);

    localparam logic [ITER_W-1:0] LAST_STEP_NQ  = ITER_W'(CNT_W - 1);
    localparam logic [ITER_W-1:0] LAST_STEP_SS  = ITER_W'(SUM_W - 1);
    localparam logic [ITER_W-1:0] LAST_STEP_DIV = ITER_W'(QUO_W - 1);

    typedef struct packed {
        logic accept;
        logic load;
        logic step_a;
        logic setup_b;
        logic step_b;
        logic setup_c;
        logic step_c;
        logic capture;
    } t_mmv_cmd;

    typedef struct packed {
        logic count_zero;
    } t_mmv_status;

endpackage

`default_nettype wire

// File: hdl/mmv_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mmv_in_if
    import mmv_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [PIX_IN_W-1:0] pixel;
    logic                       in_mask;
    logic                       frame_last;

    modport source (output valid, output pixel, output in_mask, output frame_last,
                    input ready);
    modport sink   (input valid, input pixel, input in_mask, input frame_last,
                    output ready);
endinterface

interface mmv_out_if
    import mmv_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [COUNT_W-1:0]       selected_count;
    logic                     empty_frame;

    modport source (output valid, output mean, output variance, output selected_count,
                    output empty_frame, input ready);
    modport sink   (input valid, input mean, input variance, input selected_count,
                    input empty_frame, output ready);
endinterface

`default_nettype wire

// File: hdl/mmv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mmv_ctrl
    import mmv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_last,
    output logic             o_in_ready,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    input  wire t_mmv_status i_status,
    output t_mmv_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAIN_A,
        S_DRAIN_B,
        S_LOAD,
        S_MUL_NQ,
        S_SETUP_B,
        S_MUL_SS,
        S_SETUP_C,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [ITER_W-1:0]   r_cnt;
    logic                r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:    o_cmd.accept  = i_in_valid;
            S_LOAD:    o_cmd.load    = 1'b1;
            S_MUL_NQ:  o_cmd.step_a  = 1'b1;
            S_SETUP_B: o_cmd.setup_b = 1'b1;
            S_MUL_SS:  o_cmd.step_b  = 1'b1;
            S_SETUP_C: o_cmd.setup_c = 1'b1;
            S_DIV:     o_cmd.step_c  = 1'b1;
            S_DONE:    o_cmd.capture = !r_out_valid || i_out_ready;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in_last) begin
                        r_state <= S_DRAIN_A;
                    end
                end
                // let the squaring pipeline settle into the sum of squares
                S_DRAIN_A: r_state <= S_DRAIN_B;
                S_DRAIN_B: r_state <= S_LOAD;
                S_LOAD: begin
                    if (i_status.count_zero) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL_NQ;
                        r_cnt   <= LAST_STEP_NQ;
                    end
                end
                S_MUL_NQ: begin
                    if (r_cnt == '0) begin
                        r_state <= S_SETUP_B;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SETUP_B: begin
                    r_state <= S_MUL_SS;
                    r_cnt   <= LAST_STEP_SS;
                end
                S_MUL_SS: begin
                    if (r_cnt == '0) begin
                        r_state <= S_SETUP_C;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SETUP_C: begin
                    r_state <= S_DIV;
                    r_cnt   <= LAST_STEP_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no new pixel while the last one drains through the squaring pipeline
    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=>
            !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("pixel taken while frame results pending");

    // a finished result waits while the previous one is still stalled
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result overwrote a stalled result");

endmodule

`default_nettype wire

// File: hdl/mmv_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mmv_datapath
    import mmv_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_mmv_cmd                   i_cmd,
    input  wire logic signed [PIX_IN_W-1:0] i_pixel,
    input  wire logic                       i_in_mask,
    output t_mmv_status                     o_status,
    output logic signed [MEAN_W-1:0]        o_mean,
    output logic [VAR_W-1:0]                o_variance,
    output logic [COUNT_W-1:0]              o_count,
    output logic                            o_empty
);

    // accumulators
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_count;
    logic [SSQ_W-1:0]        r_ssq;

    // squaring pipeline
    logic                    r_p1_sel;
    logic [MAG_W-1:0]        r_p1_mag;
    logic                    r_p2_sel;
    logic [SQ_W-1:0]         r_p2_sq;

    // frame-end operands and iteration registers
    logic [CNT_W-1:0]        r_n;
    logic [SUM_W-1:0]        r_smag;
    logic                    r_sneg;
    logic                    r_empty;
    logic [SUM_W-1:0]        r_mplier;
    logic [ACC_W-1:0]        r_mcand;
    logic [ACC_W-1:0]        r_acc;
    logic [NN_W-1:0]         r_nn_mcand;
    logic [NN_W-1:0]         r_nn;
    logic [CNT_W-1:0]        r_mrem;
    logic [SUM_W-1:0]        r_mquo;
    logic [NN_W-1:0]         r_drem;
    logic [QUO_W-1:0]        r_dquo;

    // result register
    logic signed [MEAN_W-1:0] r_o_mean;
    logic [VAR_W-1:0]         r_o_var;
    logic [COUNT_W-1:0]       r_o_count;
    logic                     r_o_empty;

    logic signed [PIXEL_WIDTH-1:0] w_pix;
    logic [MAG_W-1:0]              w_mag;
    logic                          w_sel;
    logic [SQ_W-1:0]               w_sq;
    logic [SUM_W-1:0]              w_sum_mag;
    logic [CNT_W:0]                w_mtry;
    logic                          w_mfit;
    logic [NN_W:0]                 w_dtry;
    logic                          w_dfit;
    logic signed [SUM_W-1:0]       w_mean;

    assign w_pix     = PIXEL_WIDTH'(i_pixel);
    assign w_mag     = w_pix[PIXEL_WIDTH-1] ? MAG_W'(-w_pix) : MAG_W'(w_pix);
    // count saturates once it reaches the frame capacity
    assign w_sel     = i_cmd.accept && i_in_mask && !r_count[CNT_W-1];
    assign w_sq      = r_p1_mag * r_p1_mag;
    assign w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    // restoring division steps: mean magnitude and variance
    assign w_mtry = {r_mrem, r_mquo[SUM_W-1]};
    assign w_mfit = (w_mtry >= {1'b0, r_n});
    assign w_dtry = {r_drem, r_dquo[QUO_W-1]};
    assign w_dfit = (w_dtry >= {1'b0, r_nn});

    assign w_mean = r_sneg ? -$signed(r_mquo) : $signed(r_mquo);

    assign o_status.count_zero = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_ssq    <= '0;
            r_p1_sel <= 1'b0;
            r_p2_sel <= 1'b0;
        end else begin
            r_p1_sel <= w_sel;
            r_p2_sel <= r_p1_sel;
            if (i_cmd.load) begin
                r_sum   <= '0;
                r_count <= '0;
                r_ssq   <= '0;
            end else begin
                if (w_sel) begin
                    r_sum   <= r_sum + SUM_W'(w_pix);
                    r_count <= r_count + 1'b1;
                end
                if (r_p2_sel) begin
                    r_ssq <= r_ssq + SSQ_W'(r_p2_sq);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_mag <= w_mag;
        r_p2_sq  <= w_sq;

        if (i_cmd.load) begin
            r_n        <= r_count;
            r_smag     <= w_sum_mag;
            r_sneg     <= r_sum[SUM_W-1];
            r_empty    <= (r_count == '0);
            r_mplier   <= SUM_W'(r_count);
            r_mcand    <= ACC_W'(r_ssq);
            r_acc      <= '0;
            r_nn_mcand <= NN_W'(r_count);
            r_nn       <= '0;
            r_mrem     <= '0;
            r_mquo     <= w_sum_mag;
        end

        // n * sumsq and n * n, one multiplier bit a cycle
        if (i_cmd.step_a) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
                r_nn  <= r_nn + r_nn_mcand;
            end
            r_mplier   <= r_mplier >> 1;
            r_mcand    <= r_mcand << 1;
            r_nn_mcand <= r_nn_mcand << 1;
        end

        if (i_cmd.setup_b) begin
            r_mplier <= r_smag;
            r_mcand  <= ACC_W'(r_smag);
        end

        // subtract sum^2 while the mean quotient is formed
        if (i_cmd.step_b) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc - r_mcand;
            end
            r_mplier <= r_mplier >> 1;
            r_mcand  <= r_mcand << 1;
            r_mrem   <= w_mfit ? CNT_W'(w_mtry - {1'b0, r_n}) : CNT_W'(w_mtry);
            r_mquo   <= {r_mquo[SUM_W-2:0], w_mfit};
        end

        // quotient fits in QUO_W bits, so the upper part starts below n*n
        if (i_cmd.setup_c) begin
            r_drem <= r_acc[ACC_W-1:QUO_W];
            r_dquo <= r_acc[QUO_W-1:0];
        end

        if (i_cmd.step_c) begin
            r_drem <= w_dfit ? NN_W'(w_dtry - {1'b0, r_nn}) : NN_W'(w_dtry);
            r_dquo <= {r_dquo[QUO_W-2:0], w_dfit};
        end

        if (i_cmd.capture) begin
            r_o_mean  <= r_empty ? '0 : MEAN_W'(w_mean);
            r_o_var   <= r_empty ? '0 : VAR_W'(r_dquo);
            r_o_count <= COUNT_W'(r_n);
            r_o_empty <= r_empty;
        end
    end

    assign o_mean     = r_o_mean;
    assign o_variance = r_o_var;
    assign o_count    = r_o_count;
    assign o_empty    = r_o_empty;

    a_cleared_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_count == '0 && r_sum == '0 && r_ssq == '0))
        else $error("accumulators not cleared at frame end");

    a_mean_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_b |-> (r_mrem < r_n))
        else $error("mean remainder out of range");

    a_var_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_c |-> (r_drem < r_nn))
        else $error("variance remainder out of range");

endmodule

`default_nettype wire

// File: hdl/masked_mean_variance_core.sv
// channel  dir  transfer when        payload
// i_in     in   valid && ready       pixel (s16 Q12.4), in_mask, frame_last
// o_out    out  valid && ready       mean (s16), variance (u31), selected_count (u21),
//                                    empty_frame
//
// one pixel per cycle inside a frame; pixels update sum and count at once and
// the square reaches the sum of squares through the r_p1_mag and r_p2_sq registers
// after the last pixel the pipeline drains and the bit-serial multiply and restoring
// divide in the datapath form n*sumsq - sum^2, the mean and then the variance
// an empty frame skips the arithmetic and goes from the load straight to the result register
// i_in is held off from the last pixel until the result is registered; a stalled
// result waits in the output register while the next frame streams in
// i_rst_n is synchronous, active low, and clears the accumulators and control
`timescale 1ns / 1ps
`default_nettype none

module masked_mean_variance_core
    import mmv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mmv_in_if.sink     i_in,
    mmv_out_if.source  o_out
);

    t_mmv_cmd    w_cmd;
    t_mmv_status w_status;

    mmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.frame_last),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mmv_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_pixel    (i_in.pixel),
        .i_in_mask  (i_in.in_mask),
        .o_status   (w_status),
        .o_mean     (o_out.mean),
        .o_variance (o_out.variance),
        .o_count    (o_out.selected_count),
        .o_empty    (o_out.empty_frame)
    );

endmodule

`default_nettype wire
